// ===== rtl/core/ffsa_pkg.sv =====
package ffsa_pkg;

    localparam int MAX_SEGMENTS_DEF = 32;
    localparam int ADDR_WIDTH_DEF   = 16;

    localparam int OWNER_W  = 16;
    localparam int REQ_W    = 17;
    localparam int CFG_W    = 17;
    localparam int OUT_W    = 16;
    localparam int STATUS_W = 2;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_NOSPACE = 2'd1;
    localparam t_status ST_FULL    = 2'd2;
    localparam t_status ST_NOOWNER = 2'd3;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef logic t_alu_op;

    localparam t_alu_op ALU_ADD = 1'b0;
    localparam t_alu_op ALU_SUB = 1'b1;

endpackage

// ===== rtl/core/ffsa_if.sv =====
interface ffsa_req_if;
    import ffsa_pkg::*;

    logic               valid;
    logic               ready;
    logic               func;
    logic [OWNER_W-1:0] owner_id;
    logic [REQ_W-1:0]   request_size;

    modport source (output valid, output func, output owner_id, output request_size,
                    input ready);
    modport sink   (input valid, input func, input owner_id, input request_size,
                    output ready);
endinterface

interface ffsa_rsp_if;
    import ffsa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [OUT_W-1:0]    start_address;
    logic                merged;

    modport source (output valid, output status, output start_address, output merged,
                    input ready);
    modport sink   (input valid, input status, input start_address, input merged,
                    output ready);
endinterface

interface ffsa_cfg_if;
    import ffsa_pkg::*;

    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] memory_size;

    modport source (output valid, output memory_size, input ready);
    modport sink   (input valid, input memory_size, output ready);
endinterface

// ===== rtl/core/first_fit_segment_allocator.sv =====
// First-fit segment allocator. The segment table (start, size, owner, free mark) lives in a
// single-port-write, single-port-read RAM of MAX_SEGMENTS entries and is walked by a small
// sequencer around one shared add/subtract unit. Each table entry visited is read by address,
// then checked on the registered data, so with N live segments a free or an exact-fit allocate
// visits up to N entries. A split moves each later entry up by one (read, then write) and then
// writes both halves, and an allocate that finds no fit adds a merge pass and a second walk.
// Items are handled one at a time. The request channel is not ready while an item is at
// work; a finished result waits in an output register while the next item is taken. After
// reset the initial free segment is written before any request is taken. Writing
// memory_size reinitializes the table; sizes above 2^ADDR_WIDTH saturate to it. The config
// write takes priority over a request offered in the same cycle.
module first_fit_segment_allocator #(
    parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF,
    parameter int ADDR_WIDTH   = ffsa_pkg::ADDR_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ffsa_req_if.sink   i_req,
    ffsa_rsp_if.source o_rsp,
    ffsa_cfg_if.sink   i_cfg
);
    import ffsa_pkg::*;

    // Entry layout: start, size (one bit wider than an address), owner, free mark.
    localparam int SEG_W = ADDR_WIDTH + (ADDR_WIDTH + 1) + OWNER_W + 1;
    localparam int IW    = $clog2(MAX_SEGMENTS);

    logic             ram_we;
    logic [IW-1:0]    ram_waddr;
    logic [SEG_W-1:0] ram_wdata;
    logic [IW-1:0]    ram_raddr;
    logic [SEG_W-1:0] ram_rdata;

    // Sequencer: scan, split with shift-up, merge with in-place compaction.
    ffsa_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .ADDR_WIDTH   (ADDR_WIDTH),
        .SEG_W        (SEG_W)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cfg   (i_cfg),
        .o_we    (ram_we),
        .o_waddr (ram_waddr),
        .o_wdata (ram_wdata),
        .o_raddr (ram_raddr),
        .i_rdata (ram_rdata)
    );

    // Segment table storage; entries beyond the live count may be addressed, but their data is never used.
    ffsa_seg_ram #(
        .DEPTH  (MAX_SEGMENTS),
        .DATA_W (SEG_W)
    ) u_seg_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

// ===== rtl/core/ffsa_alu.sv =====
module ffsa_alu #(
    parameter int W = 17
) (
    input  ffsa_pkg::t_alu_op i_op,
    input  logic [W-1:0]      i_a,
    input  logic [W-1:0]      i_b,
    output logic [W:0]        o_res
);
    import ffsa_pkg::*;

    // Top bit is carry on add, borrow on subtract.
    always_comb begin
        case (i_op)
            ALU_ADD: o_res = {1'b0, i_a} + {1'b0, i_b};
            ALU_SUB: o_res = {1'b0, i_a} - {1'b0, i_b};
            default: o_res = '0;
        endcase
    end

endmodule

// ===== rtl/core/ffsa_seg_ram.sv =====
module ffsa_seg_ram #(
    parameter int DEPTH  = 32,
    parameter int DATA_W = 50
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/ffsa_ctrl.sv =====
module ffsa_ctrl #(
    parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF,
    parameter int ADDR_WIDTH   = ffsa_pkg::ADDR_WIDTH_DEF,
    parameter int SEG_W        = ADDR_WIDTH + ADDR_WIDTH + 1 + ffsa_pkg::OWNER_W + 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ffsa_req_if.sink                        i_req,
    ffsa_rsp_if.source                      o_rsp,
    ffsa_cfg_if.sink                        i_cfg,
    output logic                            o_we,
    output logic [$clog2(MAX_SEGMENTS)-1:0] o_waddr,
    output logic [SEG_W-1:0]                o_wdata,
    output logic [$clog2(MAX_SEGMENTS)-1:0] o_raddr,
    input  logic [SEG_W-1:0]                i_rdata
);
    import ffsa_pkg::*;

    localparam int AW   = ADDR_WIDTH;
    localparam int SW   = ADDR_WIDTH + 1;
    localparam int CW   = (SW > REQ_W) ? SW : REQ_W;
    localparam int IW   = $clog2(MAX_SEGMENTS);
    localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
    localparam int XW   = (AW > OUT_W) ? AW : OUT_W;

    typedef struct packed {
        logic [AW-1:0]      start;
        logic [SW-1:0]      size;
        logic [OWNER_W-1:0] owner;
        logic               free;
    } t_seg;

    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_RD       = 4'd2;
    localparam logic [3:0] S_CHK      = 4'd3;
    localparam logic [3:0] S_SH_RD    = 4'd4;
    localparam logic [3:0] S_SH_WR    = 4'd5;
    localparam logic [3:0] S_WR_REM   = 4'd6;
    localparam logic [3:0] S_WR_ALLOC = 4'd7;
    localparam logic [3:0] S_MG_RD0   = 4'd8;
    localparam logic [3:0] S_MG_LD    = 4'd9;
    localparam logic [3:0] S_MG_RD    = 4'd10;
    localparam logic [3:0] S_MG_CHK   = 4'd11;
    localparam logic [3:0] S_MG_FIN   = 4'd12;
    localparam logic [3:0] S_DONE     = 4'd13;

    localparam logic [CW-1:0] SPACE_LIMIT = CW'(1) << AW;

    logic [3:0]          r_state, n_state;
    logic [CNTW-1:0]     r_count, n_count;
    logic [CNTW-1:0]     r_i, n_i;
    logic [CNTW-1:0]     r_j, n_j;
    logic [CNTW-1:0]     r_w, n_w;
    logic                r_pass, n_pass;
    logic                r_func, n_func;
    logic [OWNER_W-1:0]  r_owner, n_owner;
    logic [REQ_W-1:0]    r_req, n_req;
    t_seg                r_acc, n_acc;
    t_status             r_status, n_status;
    logic [AW-1:0]       r_addr, n_addr;
    logic                r_merged, n_merged;
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    logic [OUT_W-1:0]    r_out_addr, n_out_addr;
    logic                r_out_merged, n_out_merged;

    t_seg                rd_seg;
    t_seg                wr_seg;
    t_alu_op             alu_op;
    logic [CW-1:0]       alu_a, alu_b;
    logic [CW:0]         alu_res;
    logic [CW-1:0]       req_c;
    logic [CW-1:0]       cfg_c;
    logic [CW-1:0]       cfg_sat;
    logic [XW-1:0]       addr_x;
    logic                fits, exact;

    assign rd_seg  = t_seg'(i_rdata);
    assign req_c   = CW'(r_req);
    assign cfg_c   = CW'(i_cfg.memory_size);
    assign cfg_sat = (cfg_c > SPACE_LIMIT) ? SPACE_LIMIT : cfg_c;
    assign addr_x  = XW'(r_addr);

    ffsa_alu #(.W(CW)) u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    // Size test of the scanned entry against the request: no borrow means it fits.
    assign fits  = ~alu_res[CW];
    assign exact = (alu_res == '0);

    assign i_cfg.ready = (r_state == S_IDLE);
    assign i_req.ready = (r_state == S_IDLE) && !i_cfg.valid;

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.start_address = r_out_addr;
    assign o_rsp.merged        = r_out_merged;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_i          = r_i;
        n_j          = r_j;
        n_w          = r_w;
        n_pass       = r_pass;
        n_func       = r_func;
        n_owner      = r_owner;
        n_req        = r_req;
        n_acc        = r_acc;
        n_status     = r_status;
        n_addr       = r_addr;
        n_merged     = r_merged;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_addr   = r_out_addr;
        n_out_merged = r_out_merged;

        o_we    = 1'b0;
        o_waddr = r_i[IW-1:0];
        wr_seg  = rd_seg;
        o_raddr = r_i[IW-1:0];

        alu_op = ALU_SUB;
        alu_a  = CW'(rd_seg.size);
        alu_b  = req_c;

        case (r_state)
            S_INIT: begin
                o_we         = 1'b1;
                o_waddr      = '0;
                wr_seg.start = '0;
                wr_seg.size  = SPACE_LIMIT[SW-1:0];
                wr_seg.owner = '0;
                wr_seg.free  = 1'b1;
                n_count      = CNTW'(1);
                n_state      = S_IDLE;
            end
            S_IDLE: begin
                if (i_cfg.valid) begin
                    // Reinitialize the table to one free segment.
                    o_we         = 1'b1;
                    o_waddr      = '0;
                    wr_seg.start = '0;
                    wr_seg.size  = cfg_sat[SW-1:0];
                    wr_seg.owner = '0;
                    wr_seg.free  = 1'b1;
                    n_count      = CNTW'(1);
                end else if (i_req.valid) begin
                    n_func   = i_req.func;
                    n_owner  = i_req.owner_id;
                    n_req    = i_req.request_size;
                    n_i      = '0;
                    n_pass   = 1'b0;
                    n_merged = 1'b0;
                    if (i_req.func == FUNC_ALLOC && i_req.request_size == '0) begin
                        n_status = ST_NOSPACE;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                o_raddr = r_i[IW-1:0];
                if (r_i == r_count) begin
                    if (r_func == FUNC_FREE) begin
                        n_status = ST_NOOWNER;
                        n_state  = S_DONE;
                    end else if (!r_pass) begin
                        n_w     = '0;
                        n_state = S_MG_RD0;
                    end else begin
                        n_status = ST_NOSPACE;
                        n_state  = S_DONE;
                    end
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_func == FUNC_FREE) begin
                    if (!rd_seg.free && rd_seg.owner == r_owner) begin
                        o_we        = 1'b1;
                        o_waddr     = r_i[IW-1:0];
                        wr_seg.free = 1'b1;
                        n_addr      = rd_seg.start;
                        n_status    = ST_OK;
                        n_state     = S_DONE;
                    end else begin
                        n_i     = CNTW'(r_i + 1'b1);
                        n_state = S_RD;
                    end
                end else if (rd_seg.free && fits) begin
                    if (exact) begin
                        o_we         = 1'b1;
                        o_waddr      = r_i[IW-1:0];
                        wr_seg.owner = r_owner;
                        wr_seg.free  = 1'b0;
                        n_addr       = rd_seg.start;
                        n_status     = ST_OK;
                        n_state      = S_DONE;
                    end else if (r_count == CNTW'(MAX_SEGMENTS)) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        // Keep the start and the remainder size for the split.
                        n_acc.start = rd_seg.start;
                        n_acc.size  = alu_res[SW-1:0];
                        n_j         = r_count;
                        n_state     = S_SH_RD;
                    end
                end else begin
                    n_i     = CNTW'(r_i + 1'b1);
                    n_state = S_RD;
                end
            end
            S_SH_RD: begin
                // Move entries past the split point up by one, top first.
                o_raddr = IW'(r_j - 1'b1);
                if (r_j == CNTW'(r_i + 1'b1)) begin
                    n_state = S_WR_REM;
                end else begin
                    n_state = S_SH_WR;
                end
            end
            S_SH_WR: begin
                o_we    = 1'b1;
                o_waddr = r_j[IW-1:0];
                wr_seg  = rd_seg;
                n_j     = CNTW'(r_j - 1'b1);
                n_state = S_SH_RD;
            end
            S_WR_REM: begin
                alu_op       = ALU_ADD;
                alu_a        = CW'(r_acc.start);
                alu_b        = req_c;
                o_we         = 1'b1;
                o_waddr      = IW'(r_i + 1'b1);
                wr_seg.start = alu_res[AW-1:0];
                wr_seg.size  = r_acc.size;
                wr_seg.owner = '0;
                wr_seg.free  = 1'b1;
                n_state      = S_WR_ALLOC;
            end
            S_WR_ALLOC: begin
                o_we         = 1'b1;
                o_waddr      = r_i[IW-1:0];
                wr_seg.start = r_acc.start;
                wr_seg.size  = req_c[SW-1:0];
                wr_seg.owner = r_owner;
                wr_seg.free  = 1'b0;
                n_count      = CNTW'(r_count + 1'b1);
                n_addr       = r_acc.start;
                n_status     = ST_OK;
                n_state      = S_DONE;
            end
            S_MG_RD0: begin
                o_raddr = '0;
                n_state = S_MG_LD;
            end
            S_MG_LD: begin
                n_acc   = rd_seg;
                n_j     = CNTW'(1);
                n_state = S_MG_RD;
            end
            S_MG_RD: begin
                o_raddr = r_j[IW-1:0];
                if (r_j == r_count) begin
                    n_state = S_MG_FIN;
                end else begin
                    n_state = S_MG_CHK;
                end
            end
            S_MG_CHK: begin
                alu_op = ALU_ADD;
                alu_a  = CW'(r_acc.size);
                alu_b  = CW'(rd_seg.size);
                if (r_acc.free && rd_seg.free) begin
                    // Absorb the neighbor into the running free run.
                    n_acc.size = alu_res[SW-1:0];
                    n_merged   = 1'b1;
                end else begin
                    o_we    = 1'b1;
                    o_waddr = r_w[IW-1:0];
                    wr_seg  = r_acc;
                    n_w     = CNTW'(r_w + 1'b1);
                    n_acc   = rd_seg;
                end
                n_j     = CNTW'(r_j + 1'b1);
                n_state = S_MG_RD;
            end
            S_MG_FIN: begin
                o_we    = 1'b1;
                o_waddr = r_w[IW-1:0];
                wr_seg  = r_acc;
                n_count = CNTW'(r_w + 1'b1);
                n_pass  = 1'b1;
                n_i     = '0;
                n_state = S_RD;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_addr   = (r_status == ST_OK) ? addr_x[OUT_W-1:0] : '0;
                    n_out_merged = r_merged;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        o_wdata = wr_seg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_count     <= CNTW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i          <= n_i;
        r_j          <= n_j;
        r_w          <= n_w;
        r_pass       <= n_pass;
        r_func       <= n_func;
        r_owner      <= n_owner;
        r_req        <= n_req;
        r_acc        <= n_acc;
        r_status     <= n_status;
        r_addr       <= n_addr;
        r_merged     <= n_merged;
        r_out_status <= n_out_status;
        r_out_addr   <= n_out_addr;
        r_out_merged <= n_out_merged;
    end

endmodule
